// ----- src/ttip_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ttip_pkg
// Shared types, codes and character constants of the text to integer parser.
// ----------------------------------------------------------------------------
package ttip_pkg;

    localparam int RESULT_BITS_DEF = 32;
    localparam int OUT_BITS        = 32;
    localparam int CH_BITS         = 8;
    localparam int BASE_BITS       = 5;
    localparam int LIMIT_BITS      = 8;

    localparam logic [CH_BITS-1:0] CH_ZERO    = 8'h30;
    localparam logic [CH_BITS-1:0] CH_NINE    = 8'h39;
    localparam logic [CH_BITS-1:0] CH_A_LOWER = 8'h61;
    localparam logic [CH_BITS-1:0] CH_F_LOWER = 8'h66;
    localparam logic [CH_BITS-1:0] CH_X_LOWER = 8'h78;
    localparam logic [CH_BITS-1:0] CASE_BIT   = 8'h20;

    localparam logic [BASE_BITS-1:0] BASE_AUTO  = 5'd0;
    localparam logic [BASE_BITS-1:0] BASE_OCT   = 5'd8;
    localparam logic [BASE_BITS-1:0] BASE_DEC   = 5'd10;
    localparam logic [BASE_BITS-1:0] BASE_HEX   = 5'd16;
    localparam logic [BASE_BITS-1:0] DIGIT_NONE = 5'd16;

    localparam logic [LIMIT_BITS-1:0] LIMIT_NONE = 8'd0;
    localparam logic [LIMIT_BITS-1:0] LIMIT_ONE  = 8'd1;
    localparam logic [LIMIT_BITS-1:0] DIGITS_MAX = 8'hFF;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_DIGITS    = 3'd1,
        PH_DONE      = 3'd2,
        PH_ZERO_AUTO = 3'd3,
        PH_ZX_AUTO   = 3'd4,
        PH_ZERO_HEX  = 3'd5
    } t_phase;

    typedef enum logic [0:0] {
        CFG_NUMBER_BASE = 1'b0,
        CFG_DIGIT_LIMIT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_phase                phase;
        logic [BASE_BITS-1:0]  base;
        logic [LIMIT_BITS-1:0] digits;
    } t_ctl;

    function automatic logic [BASE_BITS-1:0] digit_value(input logic [CH_BITS-1:0] c);
        logic [CH_BITS-1:0] lc;
        logic [CH_BITS-1:0] d;
        lc = c | CASE_BIT;
        d  = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
            return d[BASE_BITS-1:0];
        end else if (lc >= CH_A_LOWER && lc <= CH_F_LOWER) begin
            d = lc - CH_A_LOWER + 8'd10;
            return d[BASE_BITS-1:0];
        end
        return DIGIT_NONE;
    endfunction

    function automatic logic is_x(input logic [CH_BITS-1:0] c);
        return (c | CASE_BIT) == CH_X_LOWER;
    endfunction

endpackage
`default_nettype wire

// ----- src/ttip_step.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ttip_step
// Next-state logic for one character: prefix handling and digit multiply-add.
// ----------------------------------------------------------------------------
module ttip_step #(
    parameter int RESULT_BITS = ttip_pkg::RESULT_BITS_DEF
) (
    input  wire logic [ttip_pkg::CH_BITS-1:0]    i_ch,
    input  wire logic                            i_first,
    input  wire logic [ttip_pkg::BASE_BITS-1:0]  i_number_base,
    input  wire logic [ttip_pkg::LIMIT_BITS-1:0] i_digit_limit,
    input  wire ttip_pkg::t_ctl                  i_ctl,
    input  wire logic [RESULT_BITS-1:0]          i_acc,
    output ttip_pkg::t_ctl                       o_ctl,
    output logic [RESULT_BITS-1:0]               o_acc
);

    logic [ttip_pkg::BASE_BITS-1:0]  w_dv;
    logic                            w_take;
    ttip_pkg::t_ctl                  w_ctl;
    logic [RESULT_BITS-1:0]          w_acc;
    logic [RESULT_BITS+ttip_pkg::BASE_BITS-1:0] w_prod;
    logic [ttip_pkg::LIMIT_BITS-1:0] w_dig_inc;

    assign w_dv = ttip_pkg::digit_value(i_ch);

    // phase decisions and operands for the digit step
    always_comb begin
        w_take = 1'b0;
        w_ctl  = i_ctl;
        w_acc  = i_acc;
        if (i_first || i_ctl.phase == ttip_pkg::PH_IDLE) begin
            w_acc        = '0;
            w_ctl.digits = '0;
            w_ctl.base   = i_number_base;
            w_ctl.phase  = ttip_pkg::PH_DIGITS;
            if (i_number_base == ttip_pkg::BASE_AUTO) begin
                if (i_ch == ttip_pkg::CH_ZERO) begin
                    w_ctl.base  = ttip_pkg::BASE_OCT;
                    w_ctl.phase = ttip_pkg::PH_ZERO_AUTO;
                end else begin
                    w_ctl.base = ttip_pkg::BASE_DEC;
                    w_take     = 1'b1;
                end
            end else if (i_number_base == ttip_pkg::BASE_HEX && i_ch == ttip_pkg::CH_ZERO) begin
                w_ctl.phase = ttip_pkg::PH_ZERO_HEX;
            end else begin
                w_take = 1'b1;
            end
        end else begin
            unique case (i_ctl.phase)
                ttip_pkg::PH_ZERO_AUTO: begin
                    if (ttip_pkg::is_x(i_ch)) w_ctl.phase = ttip_pkg::PH_ZX_AUTO;
                    else                      w_take      = 1'b1;
                end
                ttip_pkg::PH_ZX_AUTO: begin
                    if (w_dv != ttip_pkg::DIGIT_NONE) begin
                        w_ctl.base = ttip_pkg::BASE_HEX;
                        w_take     = 1'b1;
                    end else begin
                        w_ctl.phase = ttip_pkg::PH_DONE;
                    end
                end
                ttip_pkg::PH_ZERO_HEX: begin
                    if (ttip_pkg::is_x(i_ch)) begin
                        w_ctl.phase = ttip_pkg::PH_DIGITS;
                    end else begin
                        // leading zero counts as a digit first
                        w_acc        = '0;
                        w_ctl.digits = ttip_pkg::LIMIT_ONE;
                        if (i_digit_limit == ttip_pkg::LIMIT_ONE) w_ctl.phase = ttip_pkg::PH_DONE;
                        else                                      w_take      = 1'b1;
                    end
                end
                ttip_pkg::PH_DIGITS: w_take = 1'b1;
                default: ;
            endcase
        end
    end

    assign w_prod    = w_acc * w_ctl.base;
    assign w_dig_inc = (w_ctl.digits == ttip_pkg::DIGITS_MAX) ? w_ctl.digits
                                                              : w_ctl.digits + 8'd1;

    // digit step
    always_comb begin
        o_ctl = w_ctl;
        o_acc = w_acc;
        if (w_take) begin
            if (w_dv == ttip_pkg::DIGIT_NONE || w_dv >= w_ctl.base) begin
                o_ctl.phase = ttip_pkg::PH_DONE;
            end else begin
                o_acc        = w_prod[RESULT_BITS-1:0]
                             + {{(RESULT_BITS-ttip_pkg::BASE_BITS){1'b0}}, w_dv};
                o_ctl.digits = w_dig_inc;
                if (i_digit_limit != ttip_pkg::LIMIT_NONE && w_dig_inc >= i_digit_limit)
                    o_ctl.phase = ttip_pkg::PH_DONE;
                else
                    o_ctl.phase = ttip_pkg::PH_DIGITS;
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/text_to_integer_parser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// text_to_integer_parser
// Streaming unsigned integer parser, configured base or octal/hex/decimal autodetection.
// The result of a last character passes through the input register, then the
// result register; a stalled result holds that character in the input register.
// Throughput: one character per cycle while no last character waits on a stalled
// result; the parse state loop closes through one multiply-add by the active base.
// Reset: synchronous active low; clears handshake state, parse state and
// the configuration registers.
// ----------------------------------------------------------------------------
module text_to_integer_parser #(
    parameter int RESULT_BITS = ttip_pkg::RESULT_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic                              i_cfg_idx,
    input  wire logic [ttip_pkg::LIMIT_BITS-1:0]   i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [ttip_pkg::CH_BITS-1:0]      i_ch,
    input  wire logic                              i_first,
    input  wire logic                              i_last,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [ttip_pkg::OUT_BITS-1:0]          o_parsed_value
);

    logic [ttip_pkg::BASE_BITS-1:0]  r_number_base;
    logic [ttip_pkg::LIMIT_BITS-1:0] r_digit_limit;

    logic                            r_in_vld;
    logic [ttip_pkg::CH_BITS-1:0]    r_ch;
    logic                            r_first;
    logic                            r_last;

    ttip_pkg::t_ctl                  r_ctl;
    ttip_pkg::t_ctl                  n_ctl;
    logic [RESULT_BITS-1:0]          r_acc;
    logic [RESULT_BITS-1:0]          n_acc;

    logic                            r_out_vld;
    logic [ttip_pkg::OUT_BITS-1:0]   r_out_value;

    logic                            w_fire;
    logic [RESULT_BITS+ttip_pkg::OUT_BITS-1:0] w_acc_ext;

    assign w_fire     = r_in_vld && (!r_last || !r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || w_fire;
    assign w_acc_ext  = {{ttip_pkg::OUT_BITS{1'b0}}, n_acc};

    ttip_step #(
        .RESULT_BITS(RESULT_BITS)
    ) u_step (
        .i_ch         (r_ch),
        .i_first      (r_first),
        .i_number_base(r_number_base),
        .i_digit_limit(r_digit_limit),
        .i_ctl        (r_ctl),
        .i_acc        (r_acc),
        .o_ctl        (n_ctl),
        .o_acc        (n_acc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= ttip_pkg::BASE_AUTO;
            r_digit_limit <= ttip_pkg::LIMIT_NONE;
        end else if (i_cfg_we) begin
            unique case (ttip_pkg::t_cfg_idx'(i_cfg_idx))
                ttip_pkg::CFG_NUMBER_BASE: r_number_base <= i_cfg_data[ttip_pkg::BASE_BITS-1:0];
                ttip_pkg::CFG_DIGIT_LIMIT: r_digit_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_ch    <= i_ch;
            r_first <= i_first;
            r_last  <= i_last;
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.phase  <= ttip_pkg::PH_IDLE;
            r_ctl.base   <= '0;
            r_ctl.digits <= '0;
            r_acc        <= '0;
        end else if (w_fire) begin
            r_ctl.base   <= n_ctl.base;
            r_ctl.digits <= n_ctl.digits;
            r_ctl.phase  <= r_last ? ttip_pkg::PH_IDLE : n_ctl.phase;
            r_acc        <= n_acc;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fire && r_last) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_last) begin
            r_out_value <= w_acc_ext[ttip_pkg::OUT_BITS-1:0];
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_parsed_value = r_out_value;

endmodule
`default_nettype wire

// ----- src/ttip_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ttip_checker
// Port-level checks of the parser's request flow, bound to the top level.
// ----------------------------------------------------------------------------
module ttip_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_in_valid,
    input wire logic                            o_in_ready,
    input wire logic                            i_last,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_ready,
    input wire logic [ttip_pkg::OUT_BITS-1:0]   o_parsed_value
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_parsed_value))
        else $error("stalled result changed or dropped");

    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input held off without a stalled result");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready && i_last, 2))
        else $error("result without a last-marked request");

endmodule

bind text_to_integer_parser ttip_checker u_ttip_checker (.*);
`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming text to integer parser. Characters are
// sent as framed strings (prefixes, digits of the active radix, stray bytes,
// missing first or last marks) under a range of radix and digit limit
// settings. A scoreboard class tracks the parse of every accepted request and
// compares each returned value, in order, with the one it worked out. Both
// handshakes idle at random, and the output side is held off at least once
// until the input side backs up.
// ----------------------------------------------------------------------------
module tb_top;

    import ttip_pkg::*;

    localparam int          HALF_PERIOD  = 4;
    localparam int          RESET_CYCLES = 10;
    localparam int          ITEM_TARGET  = 600;
    localparam int          PHASE_ITEMS  = 70;
    localparam int          SETTLE       = 4;
    localparam int          HOLD_CYCLES  = 400;
    localparam int unsigned MAX_CYCLES   = 500_000;

    class parse_scoreboard;
        logic [BASE_BITS-1:0]  cfg_base;
        logic [LIMIT_BITS-1:0] cfg_limit;
        t_phase                phase;
        logic [BASE_BITS-1:0]  base;
        logic [OUT_BITS-1:0]   acc;
        logic [LIMIT_BITS-1:0] ndig;
        logic [OUT_BITS-1:0]   value_q[$];
        bit                    failed;

        function new();
            cfg_base  = BASE_AUTO;
            cfg_limit = LIMIT_NONE;
            phase     = PH_IDLE;
            base      = '0;
            acc       = '0;
            ndig      = '0;
            failed    = 1'b0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [LIMIT_BITS-1:0] data);
            if (idx == CFG_NUMBER_BASE) begin
                cfg_base = data[BASE_BITS-1:0];
            end else begin
                cfg_limit = data;
            end
        endfunction

        function logic [BASE_BITS-1:0] char_digit(logic [CH_BITS-1:0] c);
            logic [CH_BITS-1:0] lc;
            lc = c | CASE_BIT;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                return BASE_BITS'(c - CH_ZERO);
            end else if (lc >= CH_A_LOWER && lc <= CH_F_LOWER) begin
                return BASE_BITS'(lc - CH_A_LOWER + 8'd10);
            end
            return DIGIT_NONE;
        endfunction

        function bit is_hex_mark(logic [CH_BITS-1:0] c);
            return (c | CASE_BIT) == CH_X_LOWER;
        endfunction

        function void take_digit(logic [CH_BITS-1:0] c);
            logic [BASE_BITS-1:0] v;
            v = char_digit(c);
            if (v >= DIGIT_NONE || v >= base) begin
                phase = PH_DONE;
            end else begin
                acc = acc * {27'd0, base} + {27'd0, v};
                if (ndig != DIGITS_MAX) begin
                    ndig = ndig + 8'd1;
                end
                phase = (cfg_limit != LIMIT_NONE && ndig >= cfg_limit) ? PH_DONE : PH_DIGITS;
            end
        endfunction

        function void open_string(logic [CH_BITS-1:0] c);
            base  = cfg_base;
            acc   = '0;
            ndig  = '0;
            phase = PH_DIGITS;
            if (base == BASE_AUTO) begin
                if (c == CH_ZERO) begin
                    base  = BASE_OCT;
                    phase = PH_ZERO_AUTO;
                end else begin
                    base = BASE_DEC;
                    take_digit(c);
                end
            end else if (base == BASE_HEX && c == CH_ZERO) begin
                phase = PH_ZERO_HEX;
            end else begin
                take_digit(c);
            end
        endfunction

        function void extend_string(logic [CH_BITS-1:0] c);
            case (phase)
                PH_ZERO_AUTO: begin
                    if (is_hex_mark(c)) begin
                        phase = PH_ZX_AUTO;
                    end else begin
                        take_digit(c);
                    end
                end
                PH_ZX_AUTO: begin
                    if (char_digit(c) < DIGIT_NONE) begin
                        base = BASE_HEX;
                        take_digit(c);
                    end else begin
                        phase = PH_DONE;
                    end
                end
                PH_ZERO_HEX: begin
                    if (is_hex_mark(c)) begin
                        phase = PH_DIGITS;
                    end else begin
                        take_digit(CH_ZERO);
                        if (phase != PH_DONE) begin
                            take_digit(c);
                        end
                    end
                end
                PH_DIGITS: begin
                    take_digit(c);
                end
                default: begin
                end
            endcase
        endfunction

        function void note_char(logic [CH_BITS-1:0] c, logic f, logic l);
            if (f || phase == PH_IDLE) begin
                open_string(c);
            end else begin
                extend_string(c);
            end
            if (l) begin
                value_q.push_back(acc);
                phase = PH_IDLE;
            end
        endfunction

        function void check_value(logic [OUT_BITS-1:0] got);
            logic [OUT_BITS-1:0] want;
            if (value_q.size() == 0) begin
                $display("%0t: parsed_value expected none, actual %h", $time, got);
                failed = 1'b1;
            end else begin
                want = value_q.pop_front();
                if (got !== want) begin
                    $display("%0t: parsed_value expected %h, actual %h", $time, want, got);
                    failed = 1'b1;
                end
            end
        endfunction

        function int pending();
            return value_q.size();
        endfunction
    endclass

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we     = 1'b0;
    t_cfg_idx              cfg_idx    = CFG_NUMBER_BASE;
    logic [LIMIT_BITS-1:0] cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic [CH_BITS-1:0]    ch         = '0;
    logic                  ch_first   = 1'b0;
    logic                  ch_last    = 1'b0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic [OUT_BITS-1:0]   parsed_value;

    parse_scoreboard       sb = new();
    int unsigned           cycle_cnt = 0;
    int                    items_sent = 0;
    int                    burst_left = 0;
    bit                    steady_send = 1'b0;
    int                    hold_asks = 0;
    int                    hold_served = 0;
    logic [BASE_BITS-1:0]  cur_base = BASE_AUTO;
    logic [CH_BITS-1:0]    str_buf[$];

    text_to_integer_parser i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_ch           (ch),
        .i_first        (ch_first),
        .i_last         (ch_last),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_parsed_value (parsed_value)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == MAX_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                sb.check_value(parsed_value);
            end
            if (in_valid && in_ready) begin
                sb.note_char(ch, ch_first, ch_last);
            end
            if (cfg_we) begin
                sb.set_reg(cfg_idx, cfg_data);
            end
        end
    end

    initial begin
        int seg;
        int mode;
        forever begin
            if (hold_asks != hold_served) begin
                hold_served = hold_served + 1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(10, 150);
            repeat (seg) begin
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 7) == 0);
                    default: out_ready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    task automatic pace_sender();
        if (!steady_send) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 30);
                if ($urandom_range(0, 3) != 0) begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge clk);
                end
            end
            burst_left = burst_left - 1;
        end
    endtask

    task automatic send_req(input logic [CH_BITS-1:0] c, input logic f, input logic l);
        pace_sender();
        in_valid <= 1'b1;
        ch       <= c;
        ch_first <= f;
        ch_last  <= l;
        do @(posedge clk); while (!in_ready);
        items_sent = items_sent + 1;
    endtask

    task automatic send_buf(input bit mark_first, input bit mark_last);
        for (int i = 0; i < str_buf.size(); i++) begin
            send_req(str_buf[i], mark_first && i == 0, mark_last && i == str_buf.size() - 1);
        end
    endtask

    task automatic send_text(input string s);
        str_buf.delete();
        for (int i = 0; i < s.len(); i++) begin
            str_buf.push_back(s[i]);
        end
        send_buf(1'b1, 1'b1);
    endtask

    task automatic build_string(input int max_len);
        int                 n;
        int                 b;
        int                 v;
        int                 pick;
        logic [CH_BITS-1:0] c;
        str_buf.delete();
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
            str_buf.push_back(CH_ZERO);
        end
        if (pick < 2) begin
            str_buf.push_back($urandom_range(0, 1) ? CH_X_LOWER : (CH_X_LOWER & ~CASE_BIT));
        end
        b = (cur_base == BASE_AUTO) ? $urandom_range(8, 16) : int'(cur_base);
        n = $urandom_range(0, max_len);
        repeat (n) begin
            if ($urandom_range(0, 11) == 0) begin
                c = CH_BITS'($urandom_range(0, 255));
            end else begin
                v = $urandom_range(0, b - 1);
                if (v < 10) begin
                    c = CH_BITS'(CH_ZERO + v);
                end else begin
                    c = $urandom_range(0, 1) ? CH_A_LOWER : (CH_A_LOWER & ~CASE_BIT);
                    c = CH_BITS'(c + v - 10);
                end
            end
            str_buf.push_back(c);
        end
        if (str_buf.size() == 0) begin
            str_buf.push_back(CH_BITS'($urandom_range(0, 255)));
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apply_setting(input logic [BASE_BITS-1:0] b, input logic [LIMIT_BITS-1:0] lim);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_NUMBER_BASE;
        cfg_data <= {3'b000, b};
        @(posedge clk);
        cfg_idx  <= CFG_DIGIT_LIMIT;
        cfg_data <= lim;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_base = b;
    endtask

    initial begin
        int                    phase_end;
        int                    pick;
        logic [LIMIT_BITS-1:0] lim;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("0X1f");
        send_text("017");
        send_text("0");
        send_text("0xz");
        send_text("9A");
        send_req("5", 1'b0, 1'b0);
        send_req("7", 1'b1, 1'b1);
        send_req(8'h00, 1'b1, 1'b1);
        send_req(8'hB7, 1'b1, 1'b1);
        drain();
        apply_setting(BASE_HEX, 8'd2);
        send_text("0x123");
        send_text("0AF");

        phase_end = items_sent;
        for (int k = 0; items_sent < ITEM_TARGET + 25; k++) begin
            drain();
            case (k % 8)
                0: begin cur_base = BASE_HEX;  lim = LIMIT_NONE; end
                1: begin cur_base = 5'd1;      lim = DIGITS_MAX; end
                2: begin cur_base = BASE_AUTO; lim = LIMIT_NONE; end
                3: begin cur_base = BASE_OCT;  lim = LIMIT_ONE;  end
                4: begin cur_base = BASE_DEC;  lim = LIMIT_BITS'($urandom_range(2, 12)); end
                5: begin cur_base = 5'd15;     lim = LIMIT_NONE; end
                6: begin cur_base = 5'd2;      lim = LIMIT_BITS'($urandom_range(1, 255)); end
                default: begin
                    cur_base = BASE_BITS'($urandom_range(0, 16));
                    lim      = LIMIT_BITS'($urandom_range(0, 8));
                end
            endcase
            apply_setting(cur_base, lim);
            steady_send = ($urandom_range(0, 3) == 0);
            burst_left  = 0;

            if (k == 2) begin
                // hold the output side off and keep requests coming
                hold_asks = hold_asks + 1;
                while (hold_served != hold_asks) @(posedge clk);
                steady_send = 1'b1;
                repeat (40) begin
                    build_string(2);
                    send_buf(1'b1, 1'b1);
                end
                steady_send = 1'b0;
            end

            phase_end = phase_end + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    send_req(CH_BITS'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
                end else begin
                    build_string(($urandom_range(0, 7) == 0) ? 40 : 6);
                    send_buf(pick != 1, pick != 2);
                end
            end
        end

        // close any string left open by a dropped last mark
        send_req(CH_ZERO, 1'b1, 1'b1);
        drain();
        if (!sb.failed && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
